>>> src/woa_pkg.sv
package woa_pkg;

   localparam int MAX_FRAME_DEF = 1024;
   localparam int CFG_W         = 11;
   localparam int CSR_IDX_W     = 1;
   localparam int WIN_IDX_W     = 10;
   localparam int COEF_W        = 16;
   localparam int SAMPLE_W      = 32;
   localparam int CMD_W         = 2;
   localparam int WIN_SHIFT     = 15;

   localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 11'd1024;
   localparam logic [CFG_W-1:0] HOP_SIZE_RST   = 11'd256;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_DRAIN  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_SIZE = 1'b0,
      CSR_HOP_SIZE   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic valid;
      logic sample;
      logic emit;
      logic last;
      logic use_b;
   } op_type;

endpackage

>>> src/woa_req_if.sv
interface woa_req_if;
   logic                                valid;
   logic                                ready;
   logic [woa_pkg::CMD_W-1:0]           cmd;
   logic [woa_pkg::WIN_IDX_W-1:0]       win_index;
   logic signed [woa_pkg::COEF_W-1:0]   win_coef;
   logic signed [woa_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, cmd, win_index, win_coef, sample, input ready);
   modport sink   (input valid, cmd, win_index, win_coef, sample, output ready);
endinterface

>>> src/woa_rsp_if.sv
interface woa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [woa_pkg::SAMPLE_W-1:0] out_sample;
   logic                                last;

   modport source (output valid, out_sample, last, input ready);
   modport sink   (input valid, out_sample, last, output ready);
endinterface

>>> src/woa_win_ram.sv
module woa_win_ram #(
   parameter int MAX_FRAME = woa_pkg::MAX_FRAME_DEF
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(MAX_FRAME)-1:0]       wr_addr,
   input  logic signed [woa_pkg::COEF_W-1:0]  wr_data,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_FRAME)-1:0]       rd_addr,
   output logic signed [woa_pkg::COEF_W-1:0]  rd_data
);

   logic signed [woa_pkg::COEF_W-1:0] mem [MAX_FRAME];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/woa_ovl_ram.sv
module woa_ovl_ram #(
   parameter int MAX_FRAME = woa_pkg::MAX_FRAME_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_FRAME)-1:0]        wr_addr,
   input  logic signed [woa_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(MAX_FRAME)-1:0]        rd_addr_a,
   input  logic [$clog2(MAX_FRAME)-1:0]        rd_addr_b,
   output logic signed [woa_pkg::SAMPLE_W-1:0] rd_data_a,
   output logic signed [woa_pkg::SAMPLE_W-1:0] rd_data_b
);

   logic signed [woa_pkg::SAMPLE_W-1:0] mem [MAX_FRAME];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

>>> src/woa_ctrl.sv
module woa_ctrl #(
   parameter int MAX_FRAME = woa_pkg::MAX_FRAME_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   woa_req_if.sink                              req_chan,
   input  logic                                 csr_we,
   input  logic [woa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [woa_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                 adv,
   output woa_pkg::op_type                      op,
   output logic [$clog2(MAX_FRAME)-1:0]         addr_a,
   output logic [$clog2(MAX_FRAME)-1:0]         addr_b,
   output logic signed [woa_pkg::SAMPLE_W-1:0]  sample,
   output logic                                 rd_en,
   output logic                                 win_we,
   output logic [$clog2(MAX_FRAME)-1:0]         win_addr,
   output logic signed [woa_pkg::COEF_W-1:0]    win_data,
   output logic                                 clr_en,
   output logic [$clog2(MAX_FRAME)-1:0]         clr_addr
);

   localparam int AW  = $clog2(MAX_FRAME);
   localparam int FW  = $clog2(MAX_FRAME + 1);
   localparam int XW  = (FW > woa_pkg::CFG_W) ? FW : woa_pkg::CFG_W;
   localparam int IXW = (FW > woa_pkg::WIN_IDX_W) ? FW : woa_pkg::WIN_IDX_W;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic [woa_pkg::CFG_W-1:0]  frame_size_ff, frame_size_in;
   logic [woa_pkg::CFG_W-1:0]  hop_size_ff, hop_size_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [AW-1:0]              drain_ff, drain_in;
   logic                       first_ff, first_in;

   logic [XW-1:0]              fsz_x, hsz_x, max_x, f_x, h_x;
   logic [FW-1:0]              f, h, p_w, d_w, p_next, d_next;
   logic [IXW-1:0]             idx_x;
   logic                       accept, wrap_p, wrap_d, is_sample, is_drain, is_load;

   assign max_x = XW'(MAX_FRAME);
   assign fsz_x = XW'(frame_size_ff);
   assign hsz_x = XW'(hop_size_ff);

   always_comb begin
      if (fsz_x == '0) begin
         f_x = XW'(1);
      end else if (fsz_x > max_x) begin
         f_x = max_x;
      end else begin
         f_x = fsz_x;
      end
      if (hsz_x == '0) begin
         h_x = XW'(1);
      end else if (hsz_x > f_x) begin
         h_x = f_x;
      end else begin
         h_x = hsz_x;
      end
   end

   assign f      = FW'(f_x);
   assign h      = FW'(h_x);
   assign p_w    = FW'(pos_ff);
   assign d_w    = FW'(drain_ff);
   assign p_next = FW'(p_w + FW'(1));
   assign d_next = FW'(d_w + FW'(1));
   assign wrap_p = p_next >= f;
   assign wrap_d = d_next >= f;

   assign req_chan.ready = (state_ff == ST_RUN) && adv;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_load   = accept && (woa_pkg::cmd_type'(req_chan.cmd) == woa_pkg::CMD_LOAD);
   assign is_sample = accept && (woa_pkg::cmd_type'(req_chan.cmd) == woa_pkg::CMD_SAMPLE);
   assign is_drain  = accept && (woa_pkg::cmd_type'(req_chan.cmd) == woa_pkg::CMD_DRAIN);

   always_comb begin
      op.valid  = is_sample || is_drain;
      op.sample = is_sample;
      op.emit   = is_drain || (is_sample && !first_ff && (p_w < h));
      op.last   = is_drain && wrap_d;
      op.use_b  = p_w < FW'(f - h);
   end

   assign addr_a = is_sample ? pos_ff : drain_ff;
   assign addr_b = AW'(p_w + h);
   assign sample = req_chan.sample;
   assign rd_en  = accept;

   assign idx_x    = IXW'(req_chan.win_index);
   assign win_we   = is_load && (idx_x < IXW'(MAX_FRAME));
   assign win_addr = AW'(idx_x);
   assign win_data = req_chan.win_coef;

   assign clr_en   = state_ff == ST_CLEAR;
   assign clr_addr = clr_addr_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      frame_size_in = frame_size_ff;
      hop_size_in   = hop_size_ff;
      pos_in        = pos_ff;
      drain_in      = drain_ff;
      first_in      = first_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = AW'(clr_addr_ff + AW'(1));
            if (clr_addr_ff == AW'(MAX_FRAME - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            clr_addr_in = clr_addr_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (is_sample) begin
         if (wrap_p) begin
            pos_in   = '0;
            first_in = 1'b0;
         end else begin
            pos_in = AW'(p_next);
         end
      end
      if (is_drain) begin
         drain_in = wrap_d ? '0 : AW'(d_next);
      end

      if (csr_we) begin
         case (woa_pkg::csr_idx_type'(csr_index))
            woa_pkg::CSR_FRAME_SIZE: begin
               frame_size_in = csr_wdata;
               pos_in        = '0;
               drain_in      = '0;
            end
            woa_pkg::CSR_HOP_SIZE: begin
               hop_size_in = csr_wdata;
               pos_in      = '0;
               drain_in    = '0;
            end
            default: begin
               frame_size_in = frame_size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         frame_size_ff <= woa_pkg::FRAME_SIZE_RST;
         hop_size_ff   <= woa_pkg::HOP_SIZE_RST;
         pos_ff        <= '0;
         drain_ff      <= '0;
         first_ff      <= 1'b1;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         frame_size_ff <= frame_size_in;
         hop_size_ff   <= hop_size_in;
         pos_ff        <= pos_in;
         drain_ff      <= drain_in;
         first_ff      <= first_in;
      end
   end

endmodule

>>> src/woa_pipe.sv
module woa_pipe #(
   parameter int MAX_FRAME = woa_pkg::MAX_FRAME_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  woa_pkg::op_type                      s0_op,
   input  logic [$clog2(MAX_FRAME)-1:0]         s0_addr_a,
   input  logic [$clog2(MAX_FRAME)-1:0]         s0_addr_b,
   input  logic signed [woa_pkg::SAMPLE_W-1:0]  s0_sample,
   input  logic signed [woa_pkg::COEF_W-1:0]    rd_coef,
   input  logic signed [woa_pkg::SAMPLE_W-1:0]  rd_a,
   input  logic signed [woa_pkg::SAMPLE_W-1:0]  rd_b,
   output logic                                 adv,
   output logic                                 wr_en,
   output logic [$clog2(MAX_FRAME)-1:0]         wr_addr,
   output logic signed [woa_pkg::SAMPLE_W-1:0]  wr_data,
   woa_rsp_if.source                            rsp_chan
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam int SW = woa_pkg::SAMPLE_W;
   localparam int PW = woa_pkg::SAMPLE_W + woa_pkg::COEF_W;

   woa_pkg::op_type    s1_op_ff, s2_op_ff;
   logic [AW-1:0]      s1_addr_a_ff, s1_addr_b_ff, s2_addr_ff, lw_addr_ff;
   logic signed [SW-1:0] s1_sample_ff;
   logic signed [SW-1:0] s2_w_ff, s2_a_ff, s2_b_ff, lw_data_ff;
   logic signed [SW-1:0] rsp_data_ff;
   logic                 rsp_valid_ff, rsp_last_ff, lw_en_ff;

   logic signed [PW-1:0] prod;
   logic signed [SW-1:0] prod_lo, w_in, a_in, b_in;
   logic                 s2_we;

   assign adv = !rsp_valid_ff || rsp_chan.ready;

   assign s2_we   = s2_op_ff.valid && s2_op_ff.sample;
   assign wr_en   = adv && s2_we;
   assign wr_addr = s2_addr_ff;
   assign wr_data = s2_op_ff.use_b ? SW'(s2_b_ff + s2_w_ff) : s2_w_ff;

   // forward the write in flight, then the one just committed
   always_comb begin
      if (s2_we && (s2_addr_ff == s1_addr_a_ff)) begin
         a_in = wr_data;
      end else if (lw_en_ff && (lw_addr_ff == s1_addr_a_ff)) begin
         a_in = lw_data_ff;
      end else begin
         a_in = rd_a;
      end
      if (s2_we && (s2_addr_ff == s1_addr_b_ff)) begin
         b_in = wr_data;
      end else if (lw_en_ff && (lw_addr_ff == s1_addr_b_ff)) begin
         b_in = lw_data_ff;
      end else begin
         b_in = rd_b;
      end
   end

   assign prod    = PW'(rd_coef) * PW'(s1_sample_ff);
   assign prod_lo = prod[SW-1:0];
   assign w_in    = prod_lo >>> woa_pkg::WIN_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff     <= '0;
         s2_op_ff     <= '0;
         lw_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_op_ff     <= s0_op;
         s2_op_ff     <= s1_op_ff;
         lw_en_ff     <= s2_we;
         rsp_valid_ff <= s2_op_ff.valid && s2_op_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_a_ff <= s0_addr_a;
         s1_addr_b_ff <= s0_addr_b;
         s1_sample_ff <= s0_sample;
         s2_addr_ff   <= s1_addr_a_ff;
         s2_w_ff      <= w_in;
         s2_a_ff      <= a_in;
         s2_b_ff      <= b_in;
         lw_addr_ff   <= s2_addr_ff;
         lw_data_ff   <= wr_data;
         rsp_data_ff  <= s2_a_ff;
         rsp_last_ff  <= s2_op_ff.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_sample = rsp_data_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule

>>> src/windowed_overlap_add_core.sv
// Path: a result passes the stage-1, stage-2 and response registers before rsp_chan shows it.
// Throughput: one request transaction per cycle unless rsp_chan stalls, set by the overlap
// RAM's two read ports and one write port with forwarding of the two newest writes.
// Reset: synchronous; afterwards the overlap RAM is swept to zero address by address,
// during which no request transaction is taken. The window RAM is not cleared.
module windowed_overlap_add_core #(
   parameter int MAX_FRAME = woa_pkg::MAX_FRAME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   woa_req_if.sink                        req_chan,
   woa_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [woa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [woa_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam int SW = woa_pkg::SAMPLE_W;

   woa_pkg::op_type                  op;
   logic [AW-1:0]                    addr_a, addr_b, win_addr, clr_addr, pipe_wr_addr;
   logic [AW-1:0]                    ovl_wr_addr;
   logic signed [SW-1:0]             sample, rd_a, rd_b, pipe_wr_data, ovl_wr_data;
   logic signed [woa_pkg::COEF_W-1:0] win_data, rd_coef;
   logic                             adv, rd_en, win_we, clr_en, pipe_wr_en, ovl_wr_en;

   woa_ctrl #(.MAX_FRAME(MAX_FRAME)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .adv       (adv),
      .op        (op),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .sample    (sample),
      .rd_en     (rd_en),
      .win_we    (win_we),
      .win_addr  (win_addr),
      .win_data  (win_data),
      .clr_en    (clr_en),
      .clr_addr  (clr_addr)
   );

   woa_win_ram #(.MAX_FRAME(MAX_FRAME)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_addr),
      .wr_data (win_data),
      .rd_en   (rd_en),
      .rd_addr (addr_a),
      .rd_data (rd_coef)
   );

   assign ovl_wr_en   = clr_en || pipe_wr_en;
   assign ovl_wr_addr = clr_en ? clr_addr : pipe_wr_addr;
   assign ovl_wr_data = clr_en ? '0 : pipe_wr_data;

   woa_ovl_ram #(.MAX_FRAME(MAX_FRAME)) u_ovl_ram (
      .clock     (clock),
      .wr_en     (ovl_wr_en),
      .wr_addr   (ovl_wr_addr),
      .wr_data   (ovl_wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   woa_pipe #(.MAX_FRAME(MAX_FRAME)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .s0_op     (op),
      .s0_addr_a (addr_a),
      .s0_addr_b (addr_b),
      .s0_sample (sample),
      .rd_coef   (rd_coef),
      .rd_a      (rd_a),
      .rd_b      (rd_b),
      .adv       (adv),
      .wr_en     (pipe_wr_en),
      .wr_addr   (pipe_wr_addr),
      .wr_data   (pipe_wr_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> tb/sv/tb_windowed_overlap_add_core.sv
`timescale 1ns / 1ps

module tb_windowed_overlap_add_core;

   localparam int LATENCY     = 3;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;
   localparam int N_PHASES    = 7;
   localparam int N_DIRECTED  = 24;

   localparam int MAX_FRAME = woa_pkg::MAX_FRAME_DEF;
   localparam int CFG_W     = woa_pkg::CFG_W;
   localparam int CSR_IDX_W = woa_pkg::CSR_IDX_W;
   localparam int WIN_IDX_W = woa_pkg::WIN_IDX_W;
   localparam int COEF_W    = woa_pkg::COEF_W;
   localparam int SAMPLE_W  = woa_pkg::SAMPLE_W;

   typedef struct packed {
      woa_pkg::cmd_type         cmd;
      logic [WIN_IDX_W-1:0]     win_index;
      logic [COEF_W-1:0]        win_coef;
      logic [SAMPLE_W-1:0]      sample;
      logic                     typed;
      logic [SAMPLE_W-1:0]      want_sample;
      logic                     want_last;
   } ola_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } ola_out_type;

   typedef struct packed {
      logic [CFG_W-1:0] frame;
      logic [CFG_W-1:0] hop;
      logic [15:0]      count;
      logic [7:0]       sample_pct;
      logic             quiet;
      logic             hold;
   } ola_phase_type;

   localparam ola_req_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{woa_pkg::CMD_LOAD,   10'd0,    16'h7FFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_LOAD,   10'd1,    16'h8000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_LOAD,   10'd2,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_LOAD,   10'd3,    16'h0001, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_LOAD,   10'd1023, 16'hFFFF, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_NONE,   10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_DRAIN,  10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_NONE,   10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{woa_pkg::CMD_SAMPLE, 10'd0,    16'h0000, 32'h0000_0000, 1'b0, 32'h0, 1'b0}
   };

   localparam ola_phase_type PHASES [N_PHASES] = '{
      '{11'd1,    11'd1,    16'd80,   8'd80, 1'b0, 1'b1},
      '{11'd4,    11'd2,    16'd100,  8'd80, 1'b0, 1'b0},
      '{11'd7,    11'd0,    16'd100,  8'd75, 1'b0, 1'b0},
      '{11'd5,    11'd2047, 16'd80,   8'd80, 1'b0, 1'b0},
      '{11'd16,   11'd5,    16'd120,  8'd80, 1'b0, 1'b0},
      '{11'd33,   11'd32,   16'd100,  8'd80, 1'b1, 1'b0},
      '{11'd1024, 11'd1024, 16'd270,  8'd97, 1'b0, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   woa_req_if req_chan ();
   woa_rsp_if rsp_chan ();

   windowed_overlap_add_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [COEF_W-1:0]   win_tab  [MAX_FRAME];
   logic [SAMPLE_W-1:0] ov_store [MAX_FRAME];
   logic [CFG_W-1:0]    cfg_frame;
   logic [CFG_W-1:0]    cfg_hop;
   int unsigned         frame_pos;
   int unsigned         drain_pos;
   bit                  first_frm;

   ola_out_type pending_out [$];
   bit          calm;
   bit          hold_rsp;
   int unsigned n_mismatch;
   int unsigned n_req;
   int unsigned n_load;
   int unsigned n_rsp;
   int unsigned n_drain_end;
   int unsigned n_cfg;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void apply_overlap_step(input ola_req_type it, output bit emits,
                                              output ola_out_type res);
      int unsigned         f;
      int unsigned         h;
      int unsigned         p;
      int unsigned         d;
      logic signed [47:0]  prod;
      logic [SAMPLE_W-1:0] w;
      emits = 1'b0;
      res   = '0;
      f = 32'(cfg_frame);
      if (f < 1) f = 1;
      if (f > MAX_FRAME) f = MAX_FRAME;
      h = 32'(cfg_hop);
      if (h < 1) h = 1;
      if (h > f) h = f;
      case (it.cmd)
         woa_pkg::CMD_LOAD: begin
            win_tab[it.win_index] = it.win_coef;
         end
         woa_pkg::CMD_SAMPLE: begin
            p = frame_pos;
            if (p >= f) p = f - 1;
            if (p < h && !first_frm) begin
               emits     = 1'b1;
               res.value = ov_store[p];
               res.last  = 1'b0;
            end
            prod = $signed(win_tab[p]) * $signed(it.sample);
            w    = $signed(prod[31:0]) >>> woa_pkg::WIN_SHIFT;
            if (p < f - h) ov_store[p] = ov_store[p + h] + w;
            else ov_store[p] = w;
            if (p + 1 >= f) begin
               frame_pos = 0;
               first_frm = 1'b0;
            end else begin
               frame_pos = p + 1;
            end
         end
         woa_pkg::CMD_DRAIN: begin
            d = drain_pos;
            if (d >= f) d = f - 1;
            emits     = 1'b1;
            res.value = ov_store[d];
            if (d + 1 >= f) begin
               res.last  = 1'b1;
               drain_pos = 0;
            end else begin
               res.last  = 1'b0;
               drain_pos = d + 1;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      n_mismatch++;
      if (n_mismatch <= 40)
         $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
   endtask

   task automatic program_window_cfg(input logic [CFG_W-1:0] frame,
                                     input logic [CFG_W-1:0] hop);
      csr_we    <= 1'b1;
      csr_index <= woa_pkg::CSR_FRAME_SIZE;
      csr_wdata <= frame;
      @(posedge clock);
      csr_index <= woa_pkg::CSR_HOP_SIZE;
      csr_wdata <= hop;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_frame = frame;
      cfg_hop   = hop;
      frame_pos = 0;
      drain_pos = 0;
      n_cfg++;
   endtask

   task automatic send_item(input ola_req_type it);
      bit          emits;
      ola_out_type res;
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= it.cmd;
      req_chan.win_index <= it.win_index;
      req_chan.win_coef  <= it.win_coef;
      req_chan.sample    <= it.sample;
      do @(posedge clock); while (!req_chan.ready);
      apply_overlap_step(it, emits, res);
      if (it.typed) begin
         emits     = 1'b1;
         res.value = it.want_sample;
         res.last  = it.want_last;
      end
      if (emits) pending_out.push_back(res);
      n_req++;
      if (it.cmd == woa_pkg::CMD_LOAD) n_load++;
   endtask

   task automatic sender_gap();
      if (!calm && !hold_rsp && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      while (pending_out.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic ola_req_type rand_item(input int unsigned sample_pct);
      ola_req_type it;
      int unsigned r;
      it = '0;
      r  = $urandom_range(0, 99);
      if (r < sample_pct) it.cmd = woa_pkg::CMD_SAMPLE;
      else if (r < sample_pct + (100 - sample_pct) / 2) it.cmd = woa_pkg::CMD_DRAIN;
      else if (r < 98) it.cmd = woa_pkg::CMD_LOAD;
      else it.cmd = woa_pkg::CMD_NONE;
      it.win_index = WIN_IDX_W'($urandom_range(0, MAX_FRAME - 1));
      it.win_coef  = COEF_W'($urandom);
      case ($urandom_range(0, 9))
         0: it.sample = 32'h7FFF_FFFF;
         1: it.sample = 32'h8000_0000;
         2: it.sample = 32'($signed(9'($urandom)));
         default: it.sample = $urandom;
      endcase
      return it;
   endfunction

   initial begin : rsp_side
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      ola_out_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_out.size() == 0) begin
            report_mismatch("unexpected out_sample", rsp_chan.out_sample, 32'h0);
         end else begin
            want = pending_out.pop_front();
            if (rsp_chan.out_sample !== want.value)
               report_mismatch("out_sample", rsp_chan.out_sample, want.value);
            if (rsp_chan.last !== want.last)
               report_mismatch("last", 32'(rsp_chan.last), 32'(want.last));
            n_rsp++;
            if (want.last) n_drain_end++;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("timeout: %0d cycles without a transaction", idle);
      $display("windowed_overlap_add_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      ola_req_type   it;
      ola_phase_type ph;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= woa_pkg::CSR_FRAME_SIZE;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= woa_pkg::CMD_NONE;
      req_chan.win_index <= '0;
      req_chan.win_coef  <= '0;
      req_chan.sample    <= '0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      n_mismatch = 0;
      n_req      = 0;
      n_load     = 0;
      n_rsp      = 0;
      n_drain_end = 0;
      n_cfg      = 0;
      cfg_frame  = woa_pkg::FRAME_SIZE_RST;
      cfg_hop    = woa_pkg::HOP_SIZE_RST;
      frame_pos  = 0;
      drain_pos  = 0;
      first_frm  = 1'b1;
      foreach (win_tab[i]) win_tab[i] = '0;
      foreach (ov_store[i]) ov_store[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      program_window_cfg(11'd4, 11'd2);
      for (int k = 0; k < N_DIRECTED; k++) begin
         send_item(DIRECTED_ROWS[k]);
         sender_gap();
      end
      req_chan.valid <= 1'b0;
      drain_pipeline();

      // fill the whole window table so later frames never read an unwritten entry
      for (int k = 0; k < MAX_FRAME; k++) begin
         it           = '0;
         it.cmd       = woa_pkg::CMD_LOAD;
         it.win_index = WIN_IDX_W'(k);
         it.win_coef  = COEF_W'($urandom);
         send_item(it);
         sender_gap();
      end
      req_chan.valid <= 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         ph = PHASES[p];
         drain_pipeline();
         program_window_cfg(ph.frame, ph.hop);
         calm     = ph.quiet;
         hold_rsp = ph.hold;
         for (int k = 0; k < 32'(ph.count); k++) begin
            if (p == N_PHASES - 1 && k == 32'(ph.count) - 200) calm = 1'b1;
            send_item(rand_item(32'(ph.sample_pct)));
            sender_gap();
         end
         req_chan.valid <= 1'b0;
      end

      drain_pipeline();
      repeat (LATENCY + 8) @(posedge clock);
      $display("covered %0d request transactions (%0d window loads) over %0d frame/hop settings",
               n_req, n_load, n_cfg);
      $display("checked %0d output samples, %0d of them drain ends", n_rsp, n_drain_end);
      if (n_mismatch == 0)
         $display("windowed_overlap_add_core regression: pass");
      else
         $display("windowed_overlap_add_core regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
src/woa_pkg.sv
src/woa_req_if.sv
src/woa_rsp_if.sv
src/woa_win_ram.sv
src/woa_ovl_ram.sv
src/woa_ctrl.sv
src/woa_pipe.sv
src/windowed_overlap_add_core.sv
tb/sv/tb_windowed_overlap_add_core.sv
